// ===== design/pan_tilt_look_at_angles_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pan/tilt aiming block
// Clocked concurrent checks, with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef PAN_TILT_LOOK_AT_ANGLES_ASSERT_SVH
`define PAN_TILT_LOOK_AT_ANGLES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTLA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ptla assertion failed");
`define PTLA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ptla assertion failed");
`else
`define PTLA_ASSERT(lbl, clk, rst_n, prop)
`define PTLA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== design/ptla_pkg.sv =====
// ---------------------------------------------------------------------------
// ptla_pkg
// Shared types and constants of the pan/tilt aiming pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ptla_pkg;

    localparam int ANG_W      = 35;   // Q30 angle
    localparam int XY_W       = 36;   // CORDIC vector
    localparam int RAD_W      = 63;
    localparam int ROOT_W     = 32;
    localparam int SQ_STEPS   = 32;
    localparam int ATAN_DEPTH = 24;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

    localparam logic [31:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [1:0] {
        ST_PRIMARY  = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_NONE     = 2'd2,
        ST_DOMAIN   = 2'd3
    } t_aim_status;

    typedef enum logic [1:0] {
        REG_EYE_HEIGHT  = 2'd0,
        REG_MAX_AGE     = 2'd1,
        REG_FALLBACK_EN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_aim_status        status;
        logic               ok;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic signed [28:0] s;
    } t_sb;

endpackage

// ===== design/pan_tilt_look_at_angles.sv =====
// ---------------------------------------------------------------------------
// pan_tilt_look_at_angles
// Picks a fresh target and turns it into head tilt and pan angles.
//
// Channel   Dir  Width       Content
// s_axis    in   160 data    target pair, one per transfer
// m_axis    out  40 data,2u  tilt, pan, status
// apb       in   4 addr      eye height, max age, fallback enable
//
// Accepts one transfer per cycle while the output is not held. Stages:
// select, square, radicand, 32 root stages, CORDIC_STEPS + 1 CORDIC
// stages, output register. The root pipeline sets the depth.
// Reset is synchronous and empties the pipeline; the APB registers return
// to their reset values. A held output stalls every stage in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pan_tilt_look_at_angles #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // px[19:0] py[39:20] pz[59:40] pfound[60] page[76:61]
    // fx[96:77] fy[116:97] fz[136:117] ffound[137] fage[153:138]
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tilt_angle[15:0] pan_angle[32:16]
    output logic [39:0]  m_axis_tdata,
    // aim_status[1:0]
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ptla_pkg::*;
`include "pan_tilt_look_at_angles_assert.svh"

    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam int CL = CORDIC_STEPS + 1;
    localparam int N  = 3 + SQ_STEPS + CL;
    localparam int TAP = 2 + SQ_STEPS;
    localparam logic signed [35:0] RND = 36'sd1 <<< (SH - 1);
    localparam logic signed [35:0] LIM = ({PI_Q30[34], PI_Q30} + RND) >>> SH;

    logic signed [15:0] r_eye;
    logic [15:0]        r_max_age;
    logic               r_fb_en;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye     <= '0;
            r_max_age <= 16'd500;
            r_fb_en   <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_EYE_HEIGHT:  r_eye     <= pwdata[15:0];
                REG_MAX_AGE:     r_max_age <= pwdata[15:0];
                REG_FALLBACK_EN: r_fb_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_EYE_HEIGHT:  prdata = {{16{r_eye[15]}}, r_eye};
            REG_MAX_AGE:     prdata = {16'd0, r_max_age};
            REG_FALLBACK_EN: prdata = {31'd0, r_fb_en};
            default:         prdata = '0;
        endcase
    end

    logic en;
    logic r_out_vld;
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // target select and domain check
    logic               w_p_ok;
    logic               w_f_ok;
    logic signed [19:0] w_x;
    logic signed [19:0] w_y;
    logic signed [19:0] w_z;
    logic               w_have;
    t_aim_status        w_src;
    logic [20:0]        w_xn;
    logic [19:0]        w_ax;
    logic [16:0]        w_e17;
    logic [16:0]        w_en17;
    logic [15:0]        w_ae;
    logic [16:0]        w_se;
    t_sb                w_sb;

    assign w_p_ok = s_axis_tdata[60]  && (s_axis_tdata[76:61] <= r_max_age);
    assign w_f_ok = s_axis_tdata[137] && (s_axis_tdata[153:138] <= r_max_age);

    always_comb begin
        if (w_p_ok) begin
            w_x = s_axis_tdata[19:0];   w_y = s_axis_tdata[39:20];
            w_z = s_axis_tdata[59:40];  w_have = 1'b1; w_src = ST_PRIMARY;
        end else begin
            w_x = s_axis_tdata[96:77];  w_y = s_axis_tdata[116:97];
            w_z = s_axis_tdata[136:117];
            w_have = r_fb_en && w_f_ok; w_src = ST_FALLBACK;
        end
    end

    assign w_xn   = -{w_x[19], w_x};
    assign w_ax   = w_x[19] ? w_xn[19:0] : w_x;
    assign w_e17  = {r_eye[15], r_eye};
    assign w_en17 = -w_e17;
    assign w_ae   = r_eye[15] ? w_en17[15:0] : r_eye;
    assign w_se   = w_x[19] ? w_en17 : w_e17;

    always_comb begin
        w_sb   = '0;
        w_sb.x = w_x;
        w_sb.y = w_y;
        w_sb.z = w_z;
        w_sb.s = {w_se, 12'd0};
        if (!w_have) begin
            w_sb.status = ST_NONE;
        end else if (w_x == 20'sd0 || {4'd0, w_ae} > w_ax) begin
            w_sb.status = ST_DOMAIN;
        end else begin
            w_sb.status = w_src;
            w_sb.ok     = 1'b1;
        end
    end

    // sideband line
    logic r_vld [0:N-1];
    t_sb  r_sb  [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < N; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= w_sb;
            for (int k = 1; k < N; k++) r_sb[k] <= r_sb[k-1];
        end
    end

    // radicand
    logic signed [39:0] w_x2;
    logic signed [31:0] w_e2;
    logic [38:0]        r_x2;
    logic [30:0]        r_e2;
    logic [38:0]        w_d;
    logic [RAD_W-1:0]   r_rad;

    assign w_x2 = r_sb[0].x * r_sb[0].x;
    assign w_e2 = r_eye * r_eye;
    assign w_d  = r_x2 - {8'd0, r_e2};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2  <= w_x2[38:0];
            r_e2  <= w_e2[30:0];
            r_rad <= {w_d, 24'd0};
        end
    end

    logic [ROOT_W-1:0] w_root;

    ptla_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // angle CORDICs
    logic signed [XY_W-1:0]  w_ax_in, w_ay_in, w_px_in, w_py_in, w_yx_in, w_yy_in;
    logic signed [20:0]      w_ny;
    logic signed [ANG_W-1:0] w_za, w_zp, w_zy;

    assign w_ny    = -{r_sb[TAP].y[19], r_sb[TAP].y};
    assign w_ax_in = {4'd0, w_root};
    assign w_ay_in = {{7{r_sb[TAP].s[28]}}, r_sb[TAP].s};
    assign w_px_in = {{4{r_sb[TAP].x[19]}}, r_sb[TAP].x, 12'd0};
    assign w_py_in = {{4{r_sb[TAP].z[19]}}, r_sb[TAP].z, 12'd0};
    assign w_yx_in = {{3{w_ny[20]}}, w_ny, 12'd0};
    assign w_yy_in = w_px_in;

    ptla_cordic #(.STEPS(CORDIC_STEPS)) u_asin (
        .i_clk (i_clk), .i_en (en), .i_x (w_ax_in), .i_y (w_ay_in), .o_z (w_za)
    );
    ptla_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk), .i_en (en), .i_x (w_px_in), .i_y (w_py_in), .o_z (w_zp)
    );
    ptla_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk), .i_en (en), .i_x (w_yx_in), .i_y (w_yy_in), .o_z (w_zy)
    );

    // round, clamp, output register
    logic signed [35:0] w_tp, w_ty, w_tilt;
    logic [15:0]        r_tilt;
    logic [16:0]        r_pan;
    t_aim_status        r_status;

    assign w_tp = ($signed({w_zp[34], w_zp}) - $signed({w_za[34], w_za}) + RND) >>> SH;
    assign w_ty = ($signed({w_zy[34], w_zy}) - $signed({HALF_PI_Q30[34], HALF_PI_Q30})
                  + RND) >>> SH;

    always_comb begin
        if (w_tp > LIM) begin
            w_tilt = LIM;
        end else if (w_tp < -LIM) begin
            w_tilt = -LIM;
        end else begin
            w_tilt = w_tp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= r_sb[N-1].status;
            r_tilt   <= r_sb[N-1].ok ? w_tilt[15:0] : 16'd0;
            r_pan    <= r_sb[N-1].ok ? w_ty[16:0] : 17'd0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_pan, r_tilt};
    assign m_axis_tuser  = r_status;

    logic signed [15:0] w_out_tilt;
    assign w_out_tilt = m_axis_tdata[15:0];

    `PTLA_ASSERT(a_no_target_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    `PTLA_ASSERT(a_tilt_clamped, i_clk, i_rst_n, m_axis_tvalid |-> (w_out_tilt <= LIM && w_out_tilt >= -LIM))
    `PTLA_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

// ===== design/ptla_isqrt.sv =====
// ---------------------------------------------------------------------------
// ptla_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ptla_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptla_pkg::RAD_W-1:0]  i_rad,
    output logic [ptla_pkg::ROOT_W-1:0] o_root
);
    import ptla_pkg::*;

    logic [63:0] r_v   [0:SQ_STEPS-1];
    logic [63:0] r_res [0:SQ_STEPS-1];
    logic [63:0] w_v   [0:SQ_STEPS-1];
    logic [63:0] w_res [0:SQ_STEPS-1];

    assign w_v[0]   = {1'b0, i_rad};
    assign w_res[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] w_t;
            logic [63:0] n_v;
            logic [63:0] n_res;
            if (k > 0) begin : g_link
                assign w_v[k]   = r_v[k-1];
                assign w_res[k] = r_res[k-1];
            end
            assign w_t = w_res[k] + BIT;
            always_comb begin
                if (w_v[k] >= w_t) begin
                    n_v   = w_v[k] - w_t;
                    n_res = (w_res[k] >> 1) + BIT;
                end else begin
                    n_v   = w_v[k];
                    n_res = w_res[k] >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k]   <= n_v;
                    r_res[k] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQ_STEPS-1][ROOT_W-1:0];

endmodule

// ===== design/ptla_cordic.sv =====
// ---------------------------------------------------------------------------
// ptla_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ptla_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ptla_pkg::XY_W-1:0]  i_x,
    input  logic signed [ptla_pkg::XY_W-1:0]  i_y,
    output logic signed [ptla_pkg::ANG_W-1:0] o_z
);
    import ptla_pkg::*;

    logic signed [XY_W-1:0]  r_x [0:STEPS];
    logic signed [XY_W-1:0]  r_y [0:STEPS];
    logic signed [ANG_W-1:0] r_z [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_z[0] <= (i_y >= 0) ? PI_Q30 : -PI_Q30;
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
            end else begin
                r_z[0] <= '0;
                r_x[0] <= i_x;
                r_y[0] <= i_y;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_iter
            localparam logic signed [ANG_W-1:0] ATN = {3'b000, ATAN_TAB[i]};
            logic signed [XY_W-1:0] w_xs;
            logic signed [XY_W-1:0] w_ys;
            assign w_xs = r_x[i] >>> i;
            assign w_ys = r_y[i] >>> i;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[i] >= 0) begin
                        r_x[i+1] <= r_x[i] + w_ys;
                        r_y[i+1] <= r_y[i] - w_xs;
                        r_z[i+1] <= r_z[i] + ATN;
                    end else begin
                        r_x[i+1] <= r_x[i] - w_ys;
                        r_y[i+1] <= r_y[i] + w_xs;
                        r_z[i+1] <= r_z[i] - ATN;
                    end
                end
            end
        end
    endgenerate

    assign o_z = r_z[STEPS];

endmodule
